FILE: design/pdq_pkg.sv
`timescale 1ns / 1ps

package pdq_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_PALETTE = 64;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int IDX_W       = $clog2(MAX_PALETTE);
   localparam int RAM_DEPTH   = 2 * MAX_WIDTH;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);
   localparam int LW_W        = 11;
   localparam int CSR_DW      = 11;
   localparam int CSR_IW      = 2;

   // one delta entry per column, one field group per channel: down-right, down, down-left
   localparam int DR_W    = 5;
   localparam int DN_W    = 8;
   localparam int DL_W    = 7;
   localparam int CH_W    = DR_W + DN_W + DL_W;
   localparam int ENTRY_W = 3 * CH_W;

   localparam int DIST_W = 18;

   localparam logic [CSR_IW-1:0] CSR_DITHER = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_PRESET = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_WIDTH  = 2'd2;

   localparam logic [LW_W-1:0] LW_RESET = 11'd1024;

   localparam logic [2:0] PRESET_NES  = 3'd0;
   localparam logic [2:0] PRESET_GB   = 3'd1;
   localparam logic [2:0] PRESET_GBP  = 3'd2;
   localparam logic [2:0] PRESET_PICO = 3'd3;
   localparam logic [2:0] PRESET_CGA  = 3'd4;
   localparam logic [2:0] PRESET_EGA  = 3'd5;
   localparam logic [2:0] PRESET_C64  = 3'd6;

   localparam int NES_LEN = 56;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_ADJUST,
      S_SEARCH,
      S_DRAIN,
      S_ERROR,
      S_WR_LEFT,
      S_WR_HERE
   } pdq_state_type;

   typedef struct packed {
      logic load;
      logic rd_above;
      logic adjust;
      logic rd_left;
      logic search_step;
      logic error_calc;
      logic wr_left;
      logic wr_here;
      logic commit;
   } pdq_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic out_room;
   } pdq_status_type;

   // colors packed as {red, green, blue}
   localparam logic [23:0] PAL_NES [0:55] = '{
      24'h7C7C7C, 24'h0000FC, 24'h0000BC, 24'h4428BC, 24'h940084, 24'hA80020, 24'hA81000,
      24'h881400, 24'h503000, 24'h007800, 24'h006800, 24'h005800, 24'h004058, 24'h000000,
      24'h000000, 24'hBCBCBC, 24'h0078F8, 24'h0058F8, 24'h6844FC, 24'hD800CC, 24'hE40058,
      24'hF83800, 24'hE45C10, 24'hAC7C00, 24'h00B800, 24'h00A800, 24'h00A844, 24'h008888,
      24'hF8F8F8, 24'h3CBCFC, 24'h6888FC, 24'h9878F8, 24'hF878F8, 24'hF85898, 24'hF87858,
      24'hFCA044, 24'hF8B800, 24'hB8F818, 24'h58D854, 24'h58F898, 24'h00E8D8, 24'h787878,
      24'hFCFCFC, 24'hA4E4FC, 24'hB8B8F8, 24'hD8B8F8, 24'hF8B8F8, 24'hF8A4C0, 24'hF0D0B0,
      24'hFCE0A8, 24'hF8D878, 24'hD8F878, 24'hB8F8B8, 24'hB8F8D8, 24'h00FCFC, 24'hF8D8F8
   };
   localparam logic [23:0] PAL_GB [0:3] = '{24'h0F380F, 24'h306230, 24'h8BAC0F, 24'h9BBC0F};
   localparam logic [23:0] PAL_GBP [0:3] = '{24'h0F0F0F, 24'h4F4F4F, 24'hA3A3A3, 24'hFFFFFF};
   localparam logic [23:0] PAL_PICO [0:15] = '{
      24'h000000, 24'h1D2B53, 24'h7E2553, 24'h008751, 24'hAB5236, 24'h5F574F, 24'hC2C3C7,
      24'hFFF1E8, 24'hFF004D, 24'hFFA300, 24'hFFEC27, 24'h00E436, 24'h29ADFF, 24'h83769C,
      24'hFF77A8, 24'hFFCCAA
   };
   localparam logic [23:0] PAL_CGA [0:3] = '{24'h000000, 24'h55FFFF, 24'hFF55FF, 24'hFFFFFF};
   localparam logic [23:0] PAL_EGA [0:15] = '{
      24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA, 24'hAA0000, 24'hAA00AA, 24'hAA5500,
      24'hAAAAAA, 24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFF55FF,
      24'hFFFF55, 24'hFFFFFF
   };
   localparam logic [23:0] PAL_C64 [0:15] = '{
      24'h000000, 24'hFFFFFF, 24'h880000, 24'hAAFFEE, 24'hCC44CC, 24'h00CC55, 24'h0000AA,
      24'hEEEE77, 24'hDD8855, 24'h664400, 24'hFF7777, 24'h333333, 24'h777777, 24'hAAFF66,
      24'h0088FF, 24'hBBBBBB
   };

   // unused preset code falls back to nes
   function automatic logic [23:0] pal_entry(input logic [2:0] preset,
                                             input logic [IDX_W-1:0] idx);
      logic [23:0] c;
      c = '0;
      case (preset)
         PRESET_GB:   c = PAL_GB[idx[1:0]];
         PRESET_GBP:  c = PAL_GBP[idx[1:0]];
         PRESET_PICO: c = PAL_PICO[idx[3:0]];
         PRESET_CGA:  c = PAL_CGA[idx[1:0]];
         PRESET_EGA:  c = PAL_EGA[idx[3:0]];
         PRESET_C64:  c = PAL_C64[idx[3:0]];
         default: begin
            if (idx < NES_LEN) c = PAL_NES[idx];
         end
      endcase
      return c;
   endfunction

   function automatic logic [IDX_W:0] pal_len(input logic [2:0] preset);
      logic [IDX_W:0] n;
      case (preset) inside
         PRESET_GB, PRESET_GBP, PRESET_CGA:  n = (IDX_W+1)'(4);
         PRESET_PICO, PRESET_EGA, PRESET_C64: n = (IDX_W+1)'(16);
         default:                             n = (IDX_W+1)'(NES_LEN);
      endcase
      return n;
   endfunction

endpackage

FILE: design/pdq_channels.sv
`timescale 1ns / 1ps

interface pdq_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;
   logic       frame_start;
   modport source (output valid, in_red, in_green, in_blue, frame_start, input ready);
   modport sink (input valid, in_red, in_green, in_blue, frame_start, output ready);
endinterface

interface pdq_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [7:0]                out_red;
   logic [7:0]                out_green;
   logic [7:0]                out_blue;
   logic [pdq_pkg::IDX_W-1:0] palette_index;
   logic                      row_end;
   modport source (output valid, out_red, out_green, out_blue, palette_index, row_end,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, palette_index, row_end,
                 output ready);
endinterface

interface pdq_csr_if;
   logic                       valid;
   logic                       ready;
   logic [pdq_pkg::CSR_IW-1:0] index;
   logic [pdq_pkg::CSR_DW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pdq_ram.sv
`timescale 1ns / 1ps

module pdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/pdq_ctrl.sv
`timescale 1ns / 1ps

module pdq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pdq_pkg::pdq_status_type status,
   output pdq_pkg::pdq_cmd_type    cmd
);

   pdq_pkg::pdq_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdq_pkg::S_IDLE:    if (req_valid) state_in = pdq_pkg::S_READ;
         pdq_pkg::S_READ:    state_in = pdq_pkg::S_ADJUST;
         pdq_pkg::S_ADJUST:  state_in = pdq_pkg::S_SEARCH;
         pdq_pkg::S_SEARCH:  if (status.idx_last) state_in = pdq_pkg::S_DRAIN;
         pdq_pkg::S_DRAIN:   state_in = pdq_pkg::S_ERROR;
         pdq_pkg::S_ERROR:   state_in = pdq_pkg::S_WR_LEFT;
         pdq_pkg::S_WR_LEFT: state_in = pdq_pkg::S_WR_HERE;
         pdq_pkg::S_WR_HERE: if (status.out_room) state_in = pdq_pkg::S_IDLE;
         default:            state_in = pdq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pdq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pdq_pkg::S_READ:    cmd.rd_above = 1'b1;
         pdq_pkg::S_ADJUST: begin
            cmd.adjust  = 1'b1;
            cmd.rd_left = 1'b1;
         end
         pdq_pkg::S_SEARCH:  cmd.search_step = 1'b1;
         pdq_pkg::S_DRAIN:   ;
         pdq_pkg::S_ERROR:   cmd.error_calc = 1'b1;
         pdq_pkg::S_WR_LEFT: cmd.wr_left = 1'b1;
         pdq_pkg::S_WR_HERE: begin
            cmd.wr_here = 1'b1;
            cmd.commit  = status.out_room;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pdq_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: design/pdq_datapath.sv
`timescale 1ns / 1ps

module pdq_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  pdq_pkg::pdq_cmd_type        cmd,
   output pdq_pkg::pdq_status_type     status,
   input  logic [7:0]                  in_red,
   input  logic [7:0]                  in_green,
   input  logic [7:0]                  in_blue,
   input  logic                        frame_start,
   input  logic                        csr_write,
   input  logic [pdq_pkg::CSR_IW-1:0]  csr_index,
   input  logic [pdq_pkg::CSR_DW-1:0]  csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  out_red,
   output logic [7:0]                  out_green,
   output logic [7:0]                  out_blue,
   output logic [pdq_pkg::IDX_W-1:0]   palette_index,
   output logic                        row_end
);

   localparam int CW = pdq_pkg::COL_W;
   localparam int WW = pdq_pkg::COL_W + 1;
   localparam int IW = pdq_pkg::IDX_W;
   localparam int DW = pdq_pkg::DIST_W;

   function automatic logic [7:0] clamp_add(input logic [7:0] v, input logic [7:0] dlt);
      logic signed [9:0] s;
      s = signed'({2'b00, v}) + signed'({{2{dlt[7]}}, dlt});
      if (s < 0)            return 8'd0;
      else if (s > 10'sd255) return 8'd255;
      else                  return s[7:0];
   endfunction

   // floor(e * k / 16), two's complement of the low result bits
   function automatic logic [7:0] weigh(input logic [8:0] e, input logic [3:0] k);
      logic signed [12:0] p;
      p = signed'({{4{e[8]}}, e}) * signed'({9'd0, k});
      return p[11:4];
   endfunction

   // configuration
   logic                    dither_ff, dither_in;
   logic [2:0]              preset_ff, preset_in;
   logic [pdq_pkg::LW_W-1:0] width_ff, width_in;

   // row state
   logic [CW-1:0] col_ff, col_in;
   logic          first_ff, first_in;
   logic          bank_ff, bank_in;
   logic [7:0]    rc_ff [3];
   logic [7:0]    rc_in [3];
   logic [pdq_pkg::DR_W-1:0] pb_ff [3];
   logic [pdq_pkg::DR_W-1:0] pb_in [3];

   // per pixel
   logic [7:0]    pix_ff [3];
   logic [7:0]    pix_in [3];
   logic [CW-1:0] x_ff, x_in;
   logic          last_ff, last_in;
   logic [7:0]    v_ff [3];
   logic [7:0]    v_in [3];

   // search
   logic [IW-1:0] idx_ff, idx_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic [IW-1:0] didx_ff, didx_in;
   logic          dvalid_ff, dvalid_in;
   logic [IW-1:0] best_ff, best_in;
   logic [DW-1:0] bdist_ff, bdist_in;

   // diffusion weights
   logic [7:0] w7_ff [3];
   logic [7:0] w7_in [3];
   logic [7:0] w5_ff [3];
   logic [7:0] w5_in [3];
   logic [7:0] w3_ff [3];
   logic [7:0] w3_in [3];
   logic [7:0] w1_ff [3];
   logic [7:0] w1_in [3];

   // result register
   logic          ovalid_ff, ovalid_in;
   logic [23:0]   ocolor_ff, ocolor_in;
   logic [IW-1:0] oidx_ff, oidx_in;
   logic          oend_ff, oend_in;

   // delta memory
   logic                          ram_we, ram_re;
   logic [pdq_pkg::RAM_AW-1:0]    ram_waddr, ram_raddr;
   logic [pdq_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

   logic [WW-1:0]  w_eff, w_last;
   logic [CW-1:0]  col_start;
   logic [IW:0]    pal_n;
   logic [23:0]    cand, best_color;
   logic [CW-1:0]  x_left;

   pdq_ram #(
      .WIDTH(pdq_pkg::ENTRY_W),
      .DEPTH(pdq_pkg::RAM_DEPTH)
   ) u_delta_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      if (width_ff == '0)
         w_eff = WW'(1);
      else if (width_ff > pdq_pkg::LW_W'(pdq_pkg::MAX_WIDTH))
         w_eff = WW'(pdq_pkg::MAX_WIDTH);
      else
         w_eff = WW'(width_ff);
      w_last    = w_eff - 1'b1;
      col_start = frame_start ? '0 : col_ff;
   end

   assign pal_n      = pdq_pkg::pal_len(preset_ff);
   assign cand       = pdq_pkg::pal_entry(preset_ff, idx_ff);
   assign best_color = pdq_pkg::pal_entry(preset_ff, best_ff);
   assign x_left     = x_ff - 1'b1;

   assign status.idx_last = ({1'b0, idx_ff} == pal_n - 1'b1);
   assign status.out_room = !ovalid_ff || rsp_ready;

   // memory ports
   always_comb begin
      ram_re    = cmd.rd_above || cmd.rd_left;
      ram_raddr = cmd.rd_above ? {bank_ff, x_ff} : {!bank_ff, x_left};
      ram_we    = 1'b0;
      ram_waddr = {!bank_ff, x_ff};
      ram_wdata = '0;
      for (int c = 0; c < 3; c++) begin
         ram_wdata[c*pdq_pkg::CH_W +: pdq_pkg::CH_W] =
            {pb_ff[c], w5_ff[c], {pdq_pkg::DL_W{1'b0}}};
      end
      if (cmd.wr_left) begin
         ram_we    = (x_ff != '0);
         ram_waddr = {!bank_ff, x_left};
         ram_wdata = ram_rdata;
         for (int c = 0; c < 3; c++) begin
            ram_wdata[c*pdq_pkg::CH_W +: pdq_pkg::DL_W] = w3_ff[c][pdq_pkg::DL_W-1:0];
         end
      end else if (cmd.wr_here) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      logic [pdq_pkg::CH_W-1:0] ent;
      logic [7:0]               t;
      logic [8:0]               df;
      logic signed [17:0]       de;
      logic [DW-1:0]            acc;
      logic [8:0]               e;

      dither_in = dither_ff;
      preset_in = preset_ff;
      width_in  = width_ff;
      col_in    = col_ff;
      first_in  = first_ff;
      bank_in   = bank_ff;
      rc_in     = rc_ff;
      pb_in     = pb_ff;
      pix_in    = pix_ff;
      x_in      = x_ff;
      last_in   = last_ff;
      v_in      = v_ff;
      idx_in    = idx_ff;
      dist_in   = dist_ff;
      didx_in   = idx_ff;
      dvalid_in = cmd.search_step;
      best_in   = best_ff;
      bdist_in  = bdist_ff;
      w7_in     = w7_ff;
      w5_in     = w5_ff;
      w3_in     = w3_ff;
      w1_in     = w1_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      ocolor_in = ocolor_ff;
      oidx_in   = oidx_ff;
      oend_in   = oend_ff;
      acc       = '0;
      ent       = '0;
      t         = '0;
      df        = '0;
      de        = '0;
      e         = '0;

      if (csr_write) begin
         case (csr_index)
            pdq_pkg::CSR_DITHER: dither_in = csr_data[0];
            pdq_pkg::CSR_PRESET: preset_in = csr_data[2:0];
            pdq_pkg::CSR_WIDTH:  width_in  = csr_data[pdq_pkg::LW_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         pix_in[0] = in_red;
         pix_in[1] = in_green;
         pix_in[2] = in_blue;
         if ({1'b0, col_start} >= w_eff) x_in = w_last[CW-1:0];
         else                            x_in = col_start;
         last_in = ({1'b0, x_in} == w_last);
         if (frame_start) begin
            first_in = 1'b1;
            for (int c = 0; c < 3; c++) begin
               rc_in[c] = '0;
               pb_in[c] = '0;
            end
         end
      end

      // with dithering on, take the deltas from the row above (not on the first row), then from the left neighbor
      if (cmd.adjust) begin
         idx_in = '0;
         for (int c = 0; c < 3; c++) begin
            ent = ram_rdata[c*pdq_pkg::CH_W +: pdq_pkg::CH_W];
            t   = pix_ff[c];
            if (dither_ff) begin
               if (!first_ff) begin
                  t = clamp_add(t, {{(8-pdq_pkg::DR_W){ent[pdq_pkg::CH_W-1]}},
                                    ent[pdq_pkg::CH_W-1 -: pdq_pkg::DR_W]});
                  t = clamp_add(t, ent[pdq_pkg::DL_W +: pdq_pkg::DN_W]);
                  t = clamp_add(t, {{(8-pdq_pkg::DL_W){ent[pdq_pkg::DL_W-1]}},
                                    ent[pdq_pkg::DL_W-1:0]});
               end
               t = clamp_add(t, rc_ff[c]);
            end
            v_in[c] = t;
         end
      end

      // distance to one palette entry per cycle
      if (cmd.search_step) begin
         for (int c = 0; c < 3; c++) begin
            df  = {1'b0, v_ff[c]} - {1'b0, cand[23-8*c -: 8]};
            de  = signed'({{9{df[8]}}, df});
            acc = acc + DW'(de * de);
         end
         dist_in = acc;
         idx_in  = idx_ff + 1'b1;
      end

      // lowest index wins ties
      if (dvalid_ff && (didx_ff == '0 || dist_ff < bdist_ff)) begin
         best_in  = didx_ff;
         bdist_in = dist_ff;
      end

      if (cmd.error_calc) begin
         for (int c = 0; c < 3; c++) begin
            e = dither_ff ? ({1'b0, v_ff[c]} - {1'b0, best_color[23-8*c -: 8]}) : 9'd0;
            w7_in[c] = weigh(e, 4'd7);
            w5_in[c] = weigh(e, 4'd5);
            w3_in[c] = weigh(e, 4'd3);
            w1_in[c] = weigh(e, 4'd1);
         end
      end

      if (cmd.commit) begin
         ovalid_in = 1'b1;
         ocolor_in = best_color;
         oidx_in   = best_ff;
         oend_in   = last_ff;
         for (int c = 0; c < 3; c++) begin
            rc_in[c] = last_ff ? '0 : w7_ff[c];
            pb_in[c] = last_ff ? '0 : w1_ff[c][pdq_pkg::DR_W-1:0];
         end
         if (last_ff) begin
            col_in   = '0;
            first_in = 1'b0;
            bank_in  = !bank_ff;
         end else begin
            col_in = x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= 1'b1;
         preset_ff <= pdq_pkg::PRESET_NES;
         width_ff  <= pdq_pkg::LW_RESET;
         col_ff    <= '0;
         first_ff  <= 1'b1;
         bank_ff   <= 1'b0;
         dvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            rc_ff[c] <= '0;
            pb_ff[c] <= '0;
         end
      end else begin
         dither_ff <= dither_in;
         preset_ff <= preset_in;
         width_ff  <= width_in;
         col_ff    <= col_in;
         first_ff  <= first_in;
         bank_ff   <= bank_in;
         dvalid_ff <= dvalid_in;
         ovalid_ff <= ovalid_in;
         rc_ff     <= rc_in;
         pb_ff     <= pb_in;
      end
      pix_ff    <= pix_in;
      x_ff      <= x_in;
      last_ff   <= last_in;
      v_ff      <= v_in;
      idx_ff    <= idx_in;
      dist_ff   <= dist_in;
      didx_ff   <= didx_in;
      best_ff   <= best_in;
      bdist_ff  <= bdist_in;
      w7_ff     <= w7_in;
      w5_ff     <= w5_in;
      w3_ff     <= w3_in;
      w1_ff     <= w1_in;
      ocolor_ff <= ocolor_in;
      oidx_ff   <= oidx_in;
      oend_ff   <= oend_in;
   end

   assign rsp_valid     = ovalid_ff;
   assign out_red       = ocolor_ff[23:16];
   assign out_green     = ocolor_ff[15:8];
   assign out_blue      = ocolor_ff[7:0];
   assign palette_index = oidx_ff;
   assign row_end       = oend_ff;

endmodule

FILE: design/palette_dither_quantizer_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_if    in   valid/ready    in_red, in_green, in_blue, frame_start
// rsp_if    out  valid/ready    out_red, out_green, out_blue, palette_index, row_end
// csr_if    in   valid/ready    index (0 dither, 1 preset, 2 width), data
//
// one request at a time: a new request is accepted only once the current one is
// committed to the output register; the serial distance search checks one
// palette entry per cycle
// the result sits in an output register, so a stalled rsp_if only holds the
// last step of the next request; csr writes are taken every cycle
// reset is synchronous; the delta memory needs no clearing pass

module palette_dither_quantizer_core (
   input logic          clock,
   input logic          reset,
   pdq_req_if.sink      req_if,
   pdq_rsp_if.source    rsp_if,
   pdq_csr_if.sink      csr_if
);

   pdq_pkg::pdq_cmd_type    cmd;
   pdq_pkg::pdq_status_type status;

   // config registers are plain flops, always writable
   assign csr_if.ready = 1'b1;

   // sequencer: read row above, adjust, search, error, two memory writes
   pdq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .status(status),
      .cmd(cmd)
   );

   // pixel math, palette search, delta memory and result register
   pdq_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .in_red(req_if.in_red),
      .in_green(req_if.in_green),
      .in_blue(req_if.in_blue),
      .frame_start(req_if.frame_start),
      .csr_write(csr_if.valid),
      .csr_index(csr_if.index),
      .csr_data(csr_if.data),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .out_red(rsp_if.out_red),
      .out_green(rsp_if.out_green),
      .out_blue(rsp_if.out_blue),
      .palette_index(rsp_if.palette_index),
      .row_end(rsp_if.row_end)
   );

endmodule

FILE: design/pdq_checker.sv
`timescale 1ns / 1ps

module pdq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [pdq_pkg::IDX_W-1:0] rsp_palette_index
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_palette_index < pdq_pkg::NES_LEN))
      else $error("palette index out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_palette_index)))
      else $error("stalled result dropped");

endmodule

bind palette_dither_quantizer_core pdq_checker u_pdq_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_palette_index(rsp_if.palette_index)
);
